### design/depth_window_median_assert.svh
// Assertion helpers for the depth window median block.
// Both expect a clock named aclk and an active-low reset named aresetn in scope.
`ifndef DEPTH_WINDOW_MEDIAN_ASSERT_SVH
`define DEPTH_WINDOW_MEDIAN_ASSERT_SVH

// Same-cycle implication.
`define DWM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DWM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dwm_pkg.sv
`default_nettype none

package dwm_pkg;

    localparam int DEPTH_W    = 16;
    localparam int COORD_W    = 12;
    localparam int OFFSET_W   = 4;
    localparam int SIZE_W     = 13;
    localparam int RADIUS_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH     = 3'd4;

    // reset values
    localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH   = 13'd640;
    localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT  = 13'd480;
    localparam logic [RADIUS_W-1:0] RST_WINDOW_RADIUS = 3'd2;
    localparam logic [DEPTH_W-1:0]  RST_MIN_DEPTH     = 16'd100;
    localparam logic [DEPTH_W-1:0]  RST_MAX_DEPTH     = 16'd2500;

    typedef struct packed {
        logic [COORD_W-1:0]        center_col;
        logic [COORD_W-1:0]        center_row;
        logic signed [OFFSET_W-1:0] offset_col;
        logic signed [OFFSET_W-1:0] offset_row;
        logic [DEPTH_W-1:0]        depth_raw;
        logic                      last_sample;
    } dwm_in_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] median_depth_mm;
        logic               found;
    } dwm_out_t;

endpackage

`default_nettype wire

### design/dwm_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read port.
module dwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 81
) (
    input  wire logic                                          aclk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic      [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/depth_window_median.sv
// Depth window median.
// Input channel (s_valid/s_ready/s_data): one depth sample of a square window per
// item, with the centre pixel, the sample's offset and a last mark. Samples that
// fall outside the image, outside the radius, read zero, or lie outside the
// [min, max] depth band are dropped; the others are written to a sample RAM while it has room.
// Non-last items are taken one per cycle while the block is idle.
// On the last item the block runs a radix select over the RAM: 16 passes, one
// per result bit from the MSB down, each reading all N stored samples through
// the single read port. The result then waits in a done state until the
// output register is free; with no sample kept, the select is skipped.
// No item is taken while the select runs or the done state waits.
// Result channel (m_valid/m_ready/m_data): the upper median (rank N/2) and a
// found flag; median 0 and found 0 when no sample was kept. The result sits in
// an output register; while it waits, new samples are still taken, and only the
// next window's result waits for the receiver.
// Reset (aresetn low, synchronous) loads the register defaults and empties the
// sample count; the RAM needs no clearing since only entries of the current
// window are read. Registers are written through cfg_wr_en/cfg_index/cfg_wdata.
`default_nettype none

module depth_window_median
    import dwm_pkg::*;
#(
    parameter int MAX_RADIUS = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire dwm_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output dwm_out_t                   m_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
    `include "depth_window_median_assert.svh"

    localparam int SIDE   = 2 * MAX_RADIUS + 1;
    localparam int DEPTH  = SIDE * SIDE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int BIT_W  = $clog2(DEPTH_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // configuration
    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [DEPTH_W-1:0]  min_reg;
    logic [DEPTH_W-1:0]  max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            radius_reg <= RST_WINDOW_RADIUS;
            min_reg    <= RST_MIN_DEPTH;
            max_reg    <= RST_MAX_DEPTH;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg <= cfg_wdata[SIZE_W-1:0];
                REG_WINDOW_RADIUS: radius_reg <= cfg_wdata[RADIUS_W-1:0];
                REG_MIN_DEPTH:     min_reg    <= cfg_wdata;
                REG_MAX_DEPTH:     max_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // control and select state
    logic [1:0]          state_reg,   state_next;
    logic [CNT_W-1:0]    cnt_reg,     cnt_next;
    logic [BIT_W-1:0]    bit_reg,     bit_next;
    logic [DEPTH_W-1:0]  ans_reg,     ans_next;
    logic [ADDR_W-1:0]   iss_reg,     iss_next;
    logic                issuing_reg, issuing_next;
    logic                rd_vld_reg,  rd_vld_next;
    logic                rd_last_reg, rd_last_next;
    logic [CNT_W-1:0]    lt_reg,      lt_next;
    logic                m_valid_reg, m_valid_next;
    dwm_out_t            m_data_reg,  m_data_next;

    // sample gating
    logic [COORD_W+1:0]  col_sum, row_sum;
    logic [OFFSET_W-1:0] abs_col, abs_row;
    logic [RADIUS_W-1:0] r_eff;
    logic                in_image, in_radius, in_band, keep;
    logic                accept;

    always_comb begin
        col_sum = {2'b00, s_data.center_col}
                + {{(COORD_W+2-OFFSET_W){s_data.offset_col[OFFSET_W-1]}}, s_data.offset_col};
        row_sum = {2'b00, s_data.center_row}
                + {{(COORD_W+2-OFFSET_W){s_data.offset_row[OFFSET_W-1]}}, s_data.offset_row};
        // a negative coordinate shows as the top bit of the sum
        in_image = !col_sum[COORD_W+1] && !row_sum[COORD_W+1]
                && (col_sum[SIZE_W-1:0] < width_reg)
                && (row_sum[SIZE_W-1:0] < height_reg);
        abs_col = s_data.offset_col[OFFSET_W-1] ? (OFFSET_W'(0) - s_data.offset_col)
                                                : s_data.offset_col;
        abs_row = s_data.offset_row[OFFSET_W-1] ? (OFFSET_W'(0) - s_data.offset_row)
                                                : s_data.offset_row;
        r_eff = (radius_reg > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius_reg;
        in_radius = (abs_col <= {1'b0, r_eff}) && (abs_row <= {1'b0, r_eff});
        in_band = (s_data.depth_raw != '0) && (s_data.depth_raw >= min_reg)
               && (s_data.depth_raw <= max_reg);
        keep = in_image && in_radius && in_band;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // sample RAM
    logic                ram_we;
    logic [DEPTH_W-1:0]  ram_rdata;

    assign ram_we = accept && keep && (cnt_reg < CNT_W'(DEPTH));

    dwm_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (s_data.depth_raw),
        .raddr (iss_reg),
        .rdata (ram_rdata)
    );

    // radix select: keep the largest trial value with fewer than k+1 samples below it
    logic [DEPTH_W-1:0] trial;
    logic [CNT_W-1:0]   lt_sum;
    logic [CNT_W-1:0]   rank_k;
    logic [CNT_W-1:0]   cnt_inc;

    always_comb begin
        trial   = ans_reg | (DEPTH_W'(1) << bit_reg);
        lt_sum  = lt_reg + CNT_W'(ram_rdata < trial);
        rank_k  = cnt_reg >> 1;
        cnt_inc = cnt_reg + CNT_W'(ram_we);

        state_next   = state_reg;
        cnt_next     = cnt_reg;
        bit_next     = bit_reg;
        ans_next     = ans_reg;
        iss_next     = iss_reg;
        issuing_next = issuing_reg;
        rd_vld_next  = 1'b0;
        rd_last_next = 1'b0;
        lt_next      = lt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next = cnt_inc;
                    if (s_data.last_sample) begin
                        ans_next     = '0;
                        bit_next     = BIT_W'(DEPTH_W - 1);
                        iss_next     = '0;
                        lt_next      = '0;
                        issuing_next = (cnt_inc != '0);
                        state_next   = (cnt_inc != '0) ? ST_SCAN : ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (issuing_reg) begin
                    rd_vld_next  = 1'b1;
                    rd_last_next = (CNT_W'(iss_reg) == cnt_reg - CNT_W'(1));
                    if (rd_last_next) begin
                        issuing_next = 1'b0;
                    end else begin
                        iss_next = iss_reg + ADDR_W'(1);
                    end
                end
                if (rd_vld_reg) begin
                    if (rd_last_reg) begin
                        if (lt_sum <= rank_k) begin
                            ans_next = trial;
                        end
                        lt_next = '0;
                        if (bit_reg == '0) begin
                            state_next = ST_DONE;
                        end else begin
                            bit_next     = bit_reg - BIT_W'(1);
                            iss_next     = '0;
                            issuing_next = 1'b1;
                        end
                    end else begin
                        lt_next = lt_sum;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.median_depth_mm = ans_reg;
                    m_data_next.found           = (cnt_reg != '0);
                    cnt_next                    = '0;
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            issuing_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            issuing_reg <= issuing_next;
            rd_vld_reg  <= rd_vld_next;
            rd_last_reg <= rd_last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bit_reg    <= bit_next;
        ans_reg    <= ans_next;
        iss_reg    <= iss_next;
        lt_reg     <= lt_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `DWM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH), "sample count past store depth")
    `DWM_ASSERT_IMP(a_rd_in_scan, rd_vld_reg, state_reg == ST_SCAN, "RAM read data outside select")
    `DWM_ASSERT_NXT(a_result_from_done, !m_valid_reg || m_ready,
        m_valid_reg == ($past(state_reg) == ST_DONE), "result not issued from done state")
    `DWM_ASSERT_IMP(a_empty_zero, m_valid_reg && !m_data_reg.found,
        m_data_reg.median_depth_mm == '0, "empty window with nonzero median")

endmodule

`default_nettype wire

### tb/sv/tb_depth_window_median.sv
`timescale 1ns / 100ps

// Window median checker: samples of each window go in one per item, the predictor
// below keeps its own copy of the accepted depths and of the registers, and each
// median that comes out is compared with the oldest one still owed.
module tb_depth_window_median
    import dwm_pkg::*;
();

    localparam int MAX_R         = 4;
    localparam int STORE_ENTRIES = (2 * MAX_R + 1) * (2 * MAX_R + 1);
    localparam int RANDOM_ITEMS  = 1100;
    localparam int PHASES        = 9;
    // short pause once the last median is out; the block is idle by then
    localparam int SETTLE_CYCLES = 24;
    localparam int TAIL_CYCLES   = 40;
    localparam int STALL_LIMIT   = 5000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    dwm_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    dwm_out_t              m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    depth_window_median #(
        .MAX_RADIUS(MAX_R)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: register shadow, depths kept in the open window,
    // and the medians still owed by the block.
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]   img_cols;
    logic [SIZE_W-1:0]   img_rows;
    logic [RADIUS_W-1:0] radius_reg;
    logic [DEPTH_W-1:0]  band_lo;
    logic [DEPTH_W-1:0]  band_hi;
    logic [DEPTH_W-1:0]  kept_depths[$];
    dwm_out_t            pending_medians[$];

    int  errors        = 0;
    int  samples_sent  = 0;
    int  windows_sent  = 0;
    int  results_seen  = 0;
    int  found_seen    = 0;
    int  reg_writes    = 0;
    int  stall_count   = 0;
    bit  quiet         = 1'b0;  // set for a window: neither side idles

    // Gate one sample, keep it if it passes, and on the last item of the window
    // work out the upper median (rank n/2 of the kept depths, ascending).
    function automatic bit absorb_sample(input dwm_in_t smp, output dwm_out_t res);
        int                 col, row, ocol, orow, lim, n, i, j;
        bit                 keep;
        logic [DEPTH_W-1:0] key;
        logic [DEPTH_W-1:0] sorted[STORE_ENTRIES];
        ocol = int'($signed(smp.offset_col));
        orow = int'($signed(smp.offset_row));
        col  = int'(smp.center_col) + ocol;   // no wrap: negative is off the image
        row  = int'(smp.center_row) + orow;
        lim  = (radius_reg > MAX_R) ? MAX_R : int'(radius_reg);
        keep = (col >= 0) && (row >= 0) && (col < int'(img_cols)) && (row < int'(img_rows))
            && ((ocol < 0 ? -ocol : ocol) <= lim) && ((orow < 0 ? -orow : orow) <= lim)
            && (smp.depth_raw != '0)
            && (smp.depth_raw >= band_lo) && (smp.depth_raw <= band_hi);
        // once the store is full further samples are dropped
        if (keep && kept_depths.size() < STORE_ENTRIES)
            kept_depths = {kept_depths, smp.depth_raw};
        res = '0;
        if (!smp.last_sample)
            return 1'b0;
        n = kept_depths.size();
        if (n > 0) begin
            for (i = 0; i < n; i++) begin
                key = kept_depths[i];
                j   = i;
                while (j > 0 && sorted[j-1] > key) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = key;
            end
            res.median_depth_mm = sorted[n/2];
            res.found           = 1'b1;
        end
        kept_depths.delete();
        return 1'b1;
    endfunction

    function automatic dwm_in_t pack_sample(input int ccol, input int crow, input int ocol,
                                            input int orow, input int depth, input bit last);
        dwm_in_t smp;
        smp.center_col  = ccol[COORD_W-1:0];
        smp.center_row  = crow[COORD_W-1:0];
        smp.offset_col  = ocol[OFFSET_W-1:0];
        smp.offset_row  = orow[OFFSET_W-1:0];
        smp.depth_raw   = depth[DEPTH_W-1:0];
        smp.last_sample = last;
        return smp;
    endfunction

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int p;
        if (quiet)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 65)
            return 0;
        if (p < 88)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Valid is only dropped when a gap follows, so a back-to-back item never
    // sees valid lowered and raised in the same step.
    task automatic send_sample(input dwm_in_t smp, input bit typed, input dwm_out_t want);
        int       gap;
        dwm_out_t res;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
        if (absorb_sample(smp, res)) begin
            pending_medians = {pending_medians, (typed ? want : res)};
            windows_sent++;
        end
    endtask

    // Registers are only touched once every owed median is out and the block
    // has had time to finish the write of any trailing sample.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_medians.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_IMAGE_WIDTH:   img_cols   = val[SIZE_W-1:0];
            REG_IMAGE_HEIGHT:  img_rows   = val[SIZE_W-1:0];
            REG_WINDOW_RADIUS: radius_reg = val[RADIUS_W-1:0];
            REG_MIN_DEPTH:     band_lo    = val[DEPTH_W-1:0];
            REG_MAX_DEPTH:     band_hi    = val[DEPTH_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Result side: ready high for a while, then a random stall.
    initial begin
        wait (aresetn);
        forever begin : ready_pattern
            int gap;
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check and progress watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        dwm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_medians.size() == 0) begin
                $display("%0t: result with none owed: median=%0d found=%0b",
                         $time, m_data.median_depth_mm, m_data.found);
                errors++;
            end else begin
                want = pending_medians[0];
                pending_medians.delete(0);
                if (m_data.median_depth_mm !== want.median_depth_mm) begin
                    $display("%0t: median_depth_mm expected %0d got %0d",
                             $time, want.median_depth_mm, m_data.median_depth_mm);
                    errors++;
                end
                if (m_data.found !== want.found) begin
                    $display("%0t: found expected %0b got %0b",
                             $time, want.found, m_data.found);
                    errors++;
                end
                results_seen++;
                if (want.found)
                    found_seen++;
            end
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        dwm_in_t               smp;
        bit                    typed;
        dwm_out_t              want;
    } stim_row_t;

    stim_row_t stim_rows[$];

    task automatic add_sample(input dwm_in_t smp);
        stim_row_t r;
        r.kind    = ROW_SAMPLE;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.smp     = smp;
        r.typed   = 1'b0;
        r.want    = '0;
        stim_rows = {stim_rows, r};
    endtask

    // last item of a window whose median is known by hand
    task automatic add_known(input dwm_in_t smp, input int med, input bit fnd);
        stim_row_t r;
        r.kind                 = ROW_SAMPLE;
        r.reg_idx              = '0;
        r.reg_val              = '0;
        r.smp                  = smp;
        r.typed                = 1'b1;
        r.want.median_depth_mm = med[DEPTH_W-1:0];
        r.want.found           = fnd;
        stim_rows = {stim_rows, r};
    endtask

    task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        stim_row_t r;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val[CFG_DATA_W-1:0];
        r.smp     = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        stim_rows = {stim_rows, r};
    endtask

    task automatic build_directed();
        // defaults: 640x480, radius 2, band 100..2500
        add_known(pack_sample(10, 10, 0, 0, 0, 1), 0, 1'b0);          // no reading
        add_known(pack_sample(0, 0, 0, 0, 100, 1), 100, 1'b1);        // band low edge
        add_known(pack_sample(639, 479, 0, 0, 2500, 1), 2500, 1'b1);  // far corner, band top
        add_known(pack_sample(320, 240, 0, 0, 2501, 1), 0, 1'b0);     // just above band
        add_known(pack_sample(320, 240, 0, 0, 99, 1), 0, 1'b0);       // just below band
        // mixed window: negative column, beyond radius, past right and bottom edges
        add_sample(pack_sample(0, 5, -1, 0, 500, 0));
        add_sample(pack_sample(5, 5, -2, -2, 300, 0));
        add_sample(pack_sample(5, 5, 3, 0, 400, 0));
        add_sample(pack_sample(639, 5, 1, 0, 700, 0));
        add_sample(pack_sample(5, 479, 0, 1, 800, 0));
        add_sample(pack_sample(5, 5, 0, 0, 200, 1));
        // radius register above the maximum saturates at 4
        add_reg(REG_WINDOW_RADIUS, 7);
        add_sample(pack_sample(4, 4, -4, -4, 1000, 0));
        add_sample(pack_sample(4, 4, 4, 4, 1200, 0));
        add_sample(pack_sample(10, 10, -8, 7, 1500, 0));
        add_sample(pack_sample(10, 10, -5, 0, 1400, 0));
        add_sample(pack_sample(4, 4, 0, 0, 1100, 1));
        // zero-width image drops everything
        add_reg(REG_IMAGE_WIDTH, 0);
        add_known(pack_sample(0, 0, 0, 0, 500, 1), 0, 1'b0);
        // largest image, widest band
        add_reg(REG_IMAGE_WIDTH, 4096);
        add_reg(REG_IMAGE_HEIGHT, 4096);
        add_reg(REG_MIN_DEPTH, 0);
        add_reg(REG_MAX_DEPTH, 65535);
        add_sample(pack_sample(4095, 4095, 0, 0, 65535, 0));
        add_sample(pack_sample(4095, 4095, 1, 0, 1, 0));
        add_sample(pack_sample(4095, 0, 0, 0, 0, 0));
        add_known(pack_sample(4095, 4095, -4, -4, 1, 1), 65535, 1'b1);
        // empty band: min above max
        add_reg(REG_MIN_DEPTH, 3000);
        add_reg(REG_MAX_DEPTH, 2000);
        add_known(pack_sample(100, 100, 0, 0, 2500, 1), 0, 1'b0);
        // radius 0 keeps the centre only
        add_reg(REG_WINDOW_RADIUS, 0);
        add_reg(REG_MIN_DEPTH, 1);
        add_reg(REG_MAX_DEPTH, 65535);
        add_sample(pack_sample(100, 100, 0, 1, 5000, 0));
        add_known(pack_sample(100, 100, 0, 0, 5000, 1), 5000, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Random part
    // ------------------------------------------------------------------
    task automatic apply_setting(input int phase);
        int w, h, r, lo, hi;
        case (phase)
            0: begin w = 640;  h = 480;  r = 2; lo = 100; hi = 2500;  end
            1: begin w = 4096; h = 4096; r = 7; lo = 0;   hi = 65535; end
            2: begin w = 1;    h = 1;    r = 4; lo = 1;   hi = 65535; end
            3: begin
                w  = $urandom_range(1, 4096);
                h  = $urandom_range(1, 4096);
                r  = 0;
                lo = $urandom_range(1, 65535);
                hi = lo;                       // single-value band
            end
            4: begin w = 64; h = 48; r = 4; lo = 500; hi = 60000; end
            default: begin
                w  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 4096);
                h  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 4096);
                r  = $urandom_range(0, 7);
                lo = $urandom_range(0, 3000);
                hi = lo + $urandom_range(0, 40000);
                if ($urandom_range(0, 9) == 0)
                    hi = (lo > 0) ? lo - 1 : 0;  // empty or near-empty band
            end
        endcase
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w[CFG_DATA_W-1:0]);
        write_reg(REG_IMAGE_HEIGHT, h[CFG_DATA_W-1:0]);
        write_reg(REG_WINDOW_RADIUS, r[CFG_DATA_W-1:0]);
        write_reg(REG_MIN_DEPTH, lo[CFG_DATA_W-1:0]);
        write_reg(REG_MAX_DEPTH, hi[CFG_DATA_W-1:0]);
    endtask

    function automatic int pick_center(input int extent, input int lim);
        int top, v;
        top = ((extent > 4096) ? 4096 : extent) - 1;
        if (top < 0)
            top = 0;
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, lim);     // window hangs off the low edge
            1: begin
                v = top - $urandom_range(0, lim); // window hangs off the high edge
                return (v < 0) ? 0 : v;
            end
            2: return $urandom_range(0, 4095);
            default: return $urandom_range(0, top);
        endcase
    endfunction

    function automatic int pick_depth();
        int p;
        p = $urandom_range(0, 99);
        if (p < 75)
            return $urandom_range(band_lo, band_hi);
        if (p < 83)
            return 0;
        return $urandom_range(0, 65535);
    endfunction

    // One window. Mostly a well-formed sweep over the radius with random
    // holes and depths; some noise windows, and a few that overfill the store.
    task automatic send_window(output int sent);
        dwm_in_t batch[$];
        int      lim, ccol, crow, pick, n, dr, dc, i, fill;
        pick = $urandom_range(0, 99);
        lim  = (radius_reg > MAX_R) ? MAX_R : int'(radius_reg);
        ccol = pick_center(int'(img_cols), lim);
        crow = pick_center(int'(img_rows), lim);
        quiet = ($urandom_range(0, 9) == 0);
        if (pick < 10) begin
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++)
                batch = {batch, pack_sample($urandom_range(0, 4095), $urandom_range(0, 4095),
                                            $urandom_range(0, 15), $urandom_range(0, 15),
                                            $urandom_range(0, 65535), 1'b0)};
        end else if (pick < 13) begin
            // repeated centre offset: more accepted samples than the store holds
            n = $urandom_range(STORE_ENTRIES + 1, STORE_ENTRIES + 9);
            for (i = 0; i < n; i++)
                batch = {batch, pack_sample(ccol, crow, 0, 0, pick_depth(), 1'b0)};
        end else begin
            fill = ($urandom_range(0, 1) == 0) ? 100 : 70;
            for (dr = -lim; dr <= lim; dr++)
                for (dc = -lim; dc <= lim; dc++)
                    if ($urandom_range(1, 100) <= fill) begin
                        if ($urandom_range(0, 15) == 0)
                            batch = {batch, pack_sample(ccol, crow, $urandom_range(0, 15),
                                                        $urandom_range(0, 15), pick_depth(),
                                                        1'b0)};
                        else
                            batch = {batch, pack_sample(ccol, crow, dc, dr, pick_depth(), 1'b0)};
                    end
            if (batch.size() == 0)
                batch = {batch, pack_sample(ccol, crow, 0, 0, pick_depth(), 1'b0)};
        end
        batch[batch.size()-1].last_sample = 1'b1;
        foreach (batch[k])
            send_sample(batch[k], 1'b0, '0);
        sent = batch.size();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : run
        int phase, phase_items, n;
        img_cols   = RST_IMAGE_WIDTH;
        img_rows   = RST_IMAGE_HEIGHT;
        radius_reg = RST_WINDOW_RADIUS;
        band_lo    = RST_MIN_DEPTH;
        band_hi    = RST_MAX_DEPTH;
        build_directed();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[k]) begin
            if (stim_rows[k].kind == ROW_REG) begin
                wait_idle();
                write_reg(stim_rows[k].reg_idx, stim_rows[k].reg_val);
            end else begin
                send_sample(stim_rows[k].smp, stim_rows[k].typed, stim_rows[k].want);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            apply_setting(phase);
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / PHASES) begin
                send_window(n);
                phase_items += n;
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d samples in %0d windows, %0d register writes over %0d settings",
                 samples_sent, windows_sent, reg_writes, PHASES);
        $display("%0d medians checked: %0d with samples kept, %0d empty",
                 results_seen, found_seen, results_seen - found_seen);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
